// File: hw/rtl/double_ended_queue_assert.svh
// Assertion macros used by the double-ended queue RTL.
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// Clocked check that is switched off while reset is asserted.
`define DEQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that must also hold while reset is asserted.
`define DEQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: hw/rtl/deq_pkg.sv
// Types, constants and index helpers for the double-ended queue.
`timescale 1ns / 1ps

package deq_pkg;

    localparam int DEPTH   = 32;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int DATA_W  = 32;
    localparam int REQ_W   = 3;
    localparam int STAT_W  = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_FRONT = 3'd0,
        REQ_PUSH_BACK  = 3'd1,
        REQ_POP_FRONT  = 3'd2,
        REQ_POP_BACK   = 3'd3,
        REQ_READ_ALL   = 3'd4
    } req_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } state_t;

    // Ring position of an offset from a base index; the offset is below DEPTH.
    function automatic logic [IDX_W-1:0] ring_pos(
        input logic [IDX_W-1:0] base,
        input logic [CNT_W-1:0] off
    );
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
        if (sum >= (CNT_W + 1)'(DEPTH))
        begin
            sum = sum - (CNT_W + 1)'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

// File: hw/rtl/deq_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module deq_ram #(
    parameter int DATA_W = 32,
    parameter int WORDS  = 32,
    parameter int ADDR_W = $clog2(WORDS)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [WORDS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: hw/rtl/double_ended_queue.sv
// Top level of the double-ended queue: request control, ring indexes and entry RAM.
`timescale 1ns / 1ps
`include "double_ended_queue_assert.svh"

// A request is taken at a clock edge where start is high and busy is low. Push and
// pop requests can follow each other in every cycle; their single result shows on
// the result ports, marked by done, in the cycle after the request is taken. A
// read-all request of a queue holding N entries gives N results in consecutive
// cycles (one STAT_EMPTY result if N = 0) and keeps busy high while the entries
// after the first are read, as the entry RAM has one read port and gives one entry
// per cycle. The receiver cannot stall: every result is on the ports for exactly one
// cycle and must be taken then. Request codes 5 to 7 are taken and ignored. The entry
// RAM needs no clearing pass, so the block is ready as soon as reset is released.
module double_ended_queue (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic        [deq_pkg::REQ_W-1:0]     req_type,
    input  logic signed [deq_pkg::DATA_W-1:0]    push_value,
    output logic                                 done,
    output logic signed [deq_pkg::DATA_W-1:0]    out_value,
    output logic        [deq_pkg::STAT_W-1:0]    status,
    output logic                                 is_last
);

    deq_pkg::state_t                 state_reg, state_next;
    logic [deq_pkg::IDX_W-1:0]       front_reg, front_next;
    logic [deq_pkg::CNT_W-1:0]       count_reg, count_next;
    logic [deq_pkg::IDX_W-1:0]       rd_idx_reg, rd_idx_next;

    // Result stage.
    logic                            res_valid_reg, res_valid_next;
    logic                            res_mem_reg, res_mem_next;
    logic [deq_pkg::DATA_W-1:0]      res_value_reg, res_value_next;
    logic [deq_pkg::STAT_W-1:0]      res_status_reg, res_status_next;
    logic                            res_last_reg, res_last_next;

    logic                            accept;
    logic                            is_full;
    logic                            is_empty;
    logic                            rd_is_last;

    logic                            mem_we;
    logic [deq_pkg::IDX_W-1:0]       mem_waddr;
    logic [deq_pkg::DATA_W-1:0]      mem_wdata;
    logic                            mem_re;
    logic [deq_pkg::IDX_W-1:0]       mem_raddr;
    logic [deq_pkg::DATA_W-1:0]      mem_rdata;

    assign busy       = (state_reg == deq_pkg::ST_READ);
    assign accept     = start && !busy;
    assign is_full    = (count_reg == deq_pkg::CNT_W'(deq_pkg::DEPTH));
    assign is_empty   = (count_reg == '0);
    assign rd_is_last = ({1'b0, rd_idx_reg} == (count_reg - deq_pkg::CNT_W'(1)));

    // Next state and index updates.
    always_comb
    begin
        state_next  = state_reg;
        front_next  = front_reg;
        count_next  = count_reg;
        rd_idx_next = rd_idx_reg;
        if (busy)
        begin
            if (rd_is_last)
            begin
                state_next = deq_pkg::ST_IDLE;
            end
            else
            begin
                rd_idx_next = rd_idx_reg + deq_pkg::IDX_W'(1);
            end
        end
        else if (accept)
        begin
            unique case (req_type)
                deq_pkg::REQ_PUSH_FRONT:
                begin
                    if (!is_full)
                    begin
                        front_next = deq_pkg::ring_pos(front_reg,
                                                       deq_pkg::CNT_W'(deq_pkg::DEPTH - 1));
                        count_next = count_reg + deq_pkg::CNT_W'(1);
                    end
                end
                deq_pkg::REQ_PUSH_BACK:
                begin
                    if (!is_full)
                    begin
                        count_next = count_reg + deq_pkg::CNT_W'(1);
                    end
                end
                deq_pkg::REQ_POP_FRONT:
                begin
                    if (!is_empty)
                    begin
                        front_next = deq_pkg::ring_pos(front_reg, deq_pkg::CNT_W'(1));
                        count_next = count_reg - deq_pkg::CNT_W'(1);
                    end
                end
                deq_pkg::REQ_POP_BACK:
                begin
                    if (!is_empty)
                    begin
                        count_next = count_reg - deq_pkg::CNT_W'(1);
                    end
                end
                deq_pkg::REQ_READ_ALL:
                begin
                    // A single entry is read out at once; more entries stream.
                    if (count_reg > deq_pkg::CNT_W'(1))
                    begin
                        state_next  = deq_pkg::ST_READ;
                        rd_idx_next = deq_pkg::IDX_W'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Memory control and result stage.
    always_comb
    begin
        mem_we          = 1'b0;
        mem_waddr       = front_reg;
        mem_wdata       = push_value;
        mem_re          = 1'b0;
        mem_raddr       = front_reg;
        res_valid_next  = 1'b0;
        res_mem_next    = 1'b0;
        res_value_next  = push_value;
        res_status_next = deq_pkg::STAT_OK;
        res_last_next   = 1'b1;
        if (busy)
        begin
            mem_re         = 1'b1;
            mem_raddr      = deq_pkg::ring_pos(front_reg, deq_pkg::CNT_W'(rd_idx_reg));
            res_valid_next = 1'b1;
            res_mem_next   = 1'b1;
            res_last_next  = rd_is_last;
        end
        else if (accept)
        begin
            unique case (req_type) inside
                deq_pkg::REQ_PUSH_FRONT, deq_pkg::REQ_PUSH_BACK:
                begin
                    res_valid_next = 1'b1;
                    if (is_full)
                    begin
                        res_status_next = deq_pkg::STAT_FULL;
                    end
                    else
                    begin
                        mem_we = 1'b1;
                        if (req_type == deq_pkg::REQ_PUSH_FRONT)
                        begin
                            mem_waddr = deq_pkg::ring_pos(front_reg,
                                                          deq_pkg::CNT_W'(deq_pkg::DEPTH - 1));
                        end
                        else
                        begin
                            mem_waddr = deq_pkg::ring_pos(front_reg, count_reg);
                        end
                    end
                end
                deq_pkg::REQ_POP_FRONT, deq_pkg::REQ_POP_BACK, deq_pkg::REQ_READ_ALL:
                begin
                    res_valid_next = 1'b1;
                    if (is_empty)
                    begin
                        res_value_next  = '0;
                        res_status_next = deq_pkg::STAT_EMPTY;
                    end
                    else
                    begin
                        mem_re       = 1'b1;
                        res_mem_next = 1'b1;
                        if (req_type == deq_pkg::REQ_POP_BACK)
                        begin
                            mem_raddr = deq_pkg::ring_pos(front_reg,
                                                          count_reg - deq_pkg::CNT_W'(1));
                        end
                        if (req_type == deq_pkg::REQ_READ_ALL)
                        begin
                            res_last_next = (count_reg == deq_pkg::CNT_W'(1));
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= deq_pkg::ST_IDLE;
            front_reg     <= '0;
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            res_valid_reg <= 1'b0;
            res_mem_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            count_reg     <= count_next;
            rd_idx_reg    <= rd_idx_next;
            res_valid_reg <= res_valid_next;
            res_mem_reg   <= res_mem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        res_last_reg   <= res_last_next;
    end

    deq_ram #(
        .DATA_W (deq_pkg::DATA_W),
        .WORDS  (deq_pkg::DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Popped and read-out values come straight from the RAM read register.
    assign done      = res_valid_reg;
    assign out_value = res_mem_reg ? $signed(mem_rdata) : $signed(res_value_reg);
    assign status    = res_status_reg;
    assign is_last   = res_last_reg;

    `DEQ_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> !busy && !done && (count_reg == '0), "state not cleared by reset")
    `DEQ_ASSERT(a_count_bound, count_reg <= deq_pkg::CNT_W'(deq_pkg::DEPTH), "entry count above depth")
    `DEQ_ASSERT(a_read_in_range, busy |-> ({1'b0, rd_idx_reg} < count_reg), "read-out index past the back")
    `DEQ_ASSERT(a_read_gives_result, busy |=> done, "read-out cycle without a result")
    `DEQ_ASSERT(a_read_keeps_ring, busy |=> (count_reg == $past(count_reg)) && (front_reg == $past(front_reg)), "ring changed during read-out")
    `DEQ_ASSERT(a_mem_result_ok, (done && res_mem_reg) |-> (status == deq_pkg::STAT_OK), "RAM result with error status")

endmodule

// File: tb/sv/double_ended_queue_tb.sv
// Self-checking testbench for the double-ended queue: directed corner cases and random traffic.
`timescale 1ns / 1ps

module double_ended_queue_tb;

    localparam int STALL_LIMIT = 1000;
    localparam int TAIL_CYCLES = 8;

    // Request codes above the last defined one are taken and ignored by the block.
    localparam logic [deq_pkg::REQ_W-1:0] REQ_UNDEF_FIRST = 3'd5;
    localparam logic [deq_pkg::REQ_W-1:0] REQ_UNDEF_LAST  = 3'd7;

    localparam logic signed [deq_pkg::DATA_W-1:0] VAL_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [deq_pkg::DATA_W-1:0] VAL_MIN  = 32'sh8000_0000;
    localparam logic signed [deq_pkg::DATA_W-1:0] VAL_ZERO = 32'sh0000_0000;
    localparam logic signed [deq_pkg::DATA_W-1:0] VAL_ONES = 32'shFFFF_FFFF;

    typedef struct {
        logic signed [deq_pkg::DATA_W-1:0] value;
        deq_pkg::status_t                  stat;
        logic                              last;
    } deq_result_t;

    logic                              clk;
    logic                              rst_n;
    logic                              start;
    logic                              busy;
    logic [deq_pkg::REQ_W-1:0]         req_type;
    logic signed [deq_pkg::DATA_W-1:0] push_value;
    logic                              done;
    logic signed [deq_pkg::DATA_W-1:0] out_value;
    logic [deq_pkg::STAT_W-1:0]        status;
    logic                              is_last;

    // Mirror of the queue contents, updated on every accepted request.
    logic signed [deq_pkg::DATA_W-1:0] mirror_store [deq_pkg::DEPTH];
    int                                mirror_front;
    int                                mirror_count;

    deq_result_t                       pending_results [$];
    int                                error_count;
    int                                stall_cycles;

    double_ended_queue uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req_type   (req_type),
        .push_value (push_value),
        .done       (done),
        .out_value  (out_value),
        .status     (status),
        .is_last    (is_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic expect_result(input logic signed [deq_pkg::DATA_W-1:0] value,
                                 input deq_pkg::status_t stat, input logic last);
        deq_result_t r;
        r.value = value;
        r.stat  = stat;
        r.last  = last;
        pending_results.push_back(r);
    endtask

    // Updates the mirror for one accepted request and queues the results it causes.
    task automatic apply_request(input logic [deq_pkg::REQ_W-1:0] req,
                                 input logic signed [deq_pkg::DATA_W-1:0] val);
        int slot;
        case (req) inside
            deq_pkg::REQ_PUSH_FRONT, deq_pkg::REQ_PUSH_BACK:
            begin
                if (mirror_count >= deq_pkg::DEPTH)
                begin
                    expect_result(val, deq_pkg::STAT_FULL, 1'b1);
                end
                else
                begin
                    if (req == deq_pkg::REQ_PUSH_FRONT)
                    begin
                        mirror_front = (mirror_front + deq_pkg::DEPTH - 1) % deq_pkg::DEPTH;
                        slot = mirror_front;
                    end
                    else
                    begin
                        slot = (mirror_front + mirror_count) % deq_pkg::DEPTH;
                    end
                    mirror_store[slot] = val;
                    mirror_count++;
                    expect_result(val, deq_pkg::STAT_OK, 1'b1);
                end
            end
            deq_pkg::REQ_POP_FRONT:
            begin
                if (mirror_count == 0)
                begin
                    expect_result(VAL_ZERO, deq_pkg::STAT_EMPTY, 1'b1);
                end
                else
                begin
                    expect_result(mirror_store[mirror_front], deq_pkg::STAT_OK, 1'b1);
                    mirror_front = (mirror_front + 1) % deq_pkg::DEPTH;
                    mirror_count--;
                end
            end
            deq_pkg::REQ_POP_BACK:
            begin
                if (mirror_count == 0)
                begin
                    expect_result(VAL_ZERO, deq_pkg::STAT_EMPTY, 1'b1);
                end
                else
                begin
                    slot = (mirror_front + mirror_count - 1) % deq_pkg::DEPTH;
                    expect_result(mirror_store[slot], deq_pkg::STAT_OK, 1'b1);
                    mirror_count--;
                end
            end
            deq_pkg::REQ_READ_ALL:
            begin
                if (mirror_count == 0)
                begin
                    expect_result(VAL_ZERO, deq_pkg::STAT_EMPTY, 1'b1);
                end
                else
                begin
                    for (int i = 0; i < mirror_count; i++)
                    begin
                        expect_result(mirror_store[(mirror_front + i) % deq_pkg::DEPTH],
                                      deq_pkg::STAT_OK, i == mirror_count - 1);
                    end
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // Drives one request and returns at the edge where it is accepted; start stays
    // high until the next falling edge so that a following request can go back to back.
    task automatic send_request(input logic [deq_pkg::REQ_W-1:0] req,
                                input logic signed [deq_pkg::DATA_W-1:0] val);
        @(negedge clk);
        start      <= 1'b1;
        req_type   <= req;
        push_value <= val;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        apply_request(req, val);
    endtask

    task automatic idle_for(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            start      <= 1'b0;
            req_type   <= deq_pkg::REQ_W'($urandom);
            push_value <= deq_pkg::DATA_W'($urandom);
        end
    endtask

    task automatic wait_for_drain();
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic logic signed [deq_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(0, 15))
            0:       return VAL_MAX;
            1:       return VAL_MIN;
            2:       return VAL_ZERO;
            3:       return VAL_ONES;
            default: return deq_pkg::DATA_W'($urandom);
        endcase
    endfunction

    // Picks a request with a given share of pushes among the pushes and pops.
    function automatic logic [deq_pkg::REQ_W-1:0] pick_request(input int push_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 3)
        begin
            return deq_pkg::REQ_W'($urandom_range(REQ_UNDEF_LAST, REQ_UNDEF_FIRST));
        end
        if (roll < 10)
        begin
            return deq_pkg::REQ_READ_ALL;
        end
        if ($urandom_range(0, 99) < push_pct)
        begin
            return $urandom_range(0, 1) ? deq_pkg::REQ_PUSH_FRONT : deq_pkg::REQ_PUSH_BACK;
        end
        return $urandom_range(0, 1) ? deq_pkg::REQ_POP_FRONT : deq_pkg::REQ_POP_BACK;
    endfunction

    // Runs a burst of random requests; ignored codes do not count toward the total.
    task automatic run_traffic(input int n_items, input int push_pct, input bit with_gaps);
        int                        sent;
        logic [deq_pkg::REQ_W-1:0] req;
        sent = 0;
        while (sent < n_items)
        begin
            req = pick_request(push_pct);
            send_request(req, pick_value());
            if (req <= deq_pkg::REQ_READ_ALL)
            begin
                sent++;
            end
            if (with_gaps && $urandom_range(0, 3) == 0)
            begin
                idle_for($urandom_range(1, 8));
            end
        end
    endtask

    task automatic test_empty_queue();
        send_request(deq_pkg::REQ_POP_FRONT, VAL_MAX);
        send_request(deq_pkg::REQ_POP_BACK, VAL_ONES);
        send_request(deq_pkg::REQ_READ_ALL, VAL_MIN);
        for (int code = REQ_UNDEF_FIRST; code <= REQ_UNDEF_LAST; code++)
        begin
            send_request(deq_pkg::REQ_W'(code), pick_value());
        end
    endtask

    // Extreme values through both ends, with a back pop of a lone entry and a read-all of the empty queue at the end.
    task automatic test_value_extremes();
        send_request(deq_pkg::REQ_PUSH_BACK, VAL_MAX);
        send_request(deq_pkg::REQ_PUSH_FRONT, VAL_MIN);
        send_request(deq_pkg::REQ_PUSH_BACK, VAL_ZERO);
        send_request(deq_pkg::REQ_PUSH_FRONT, VAL_ONES);
        send_request(deq_pkg::REQ_READ_ALL, VAL_ZERO);
        send_request(deq_pkg::REQ_POP_BACK, VAL_ZERO);
        send_request(deq_pkg::REQ_POP_FRONT, VAL_ZERO);
        send_request(deq_pkg::REQ_POP_BACK, VAL_ZERO);
        send_request(deq_pkg::REQ_POP_BACK, VAL_ZERO);
        send_request(deq_pkg::REQ_READ_ALL, VAL_ZERO);
    endtask

    // Fills the queue, tries both pushes on a full queue and reads all entries out.
    task automatic test_full_queue();
        for (int i = 0; i < deq_pkg::DEPTH; i++)
        begin
            send_request($urandom_range(0, 1) ? deq_pkg::REQ_PUSH_FRONT : deq_pkg::REQ_PUSH_BACK,
                         pick_value());
        end
        send_request(deq_pkg::REQ_PUSH_FRONT, pick_value());
        send_request(deq_pkg::REQ_PUSH_BACK, pick_value());
        send_request(deq_pkg::REQ_READ_ALL, pick_value());
    endtask

    task automatic test_random_traffic();
        run_traffic(70, 15, 1'b1);
        run_traffic(60, 85, 1'b1);
        run_traffic(60, 50, 1'b0);
        wait_for_drain();
        run_traffic(50, 85, 1'b1);
        run_traffic(40, 20, 1'b1);
    endtask

    task automatic test_back_to_back();
        run_traffic(20, 50, 1'b0);
    endtask

    // Result checker and stall watchdog.
    always @(posedge clk)
    begin
        deq_result_t exp_r;
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_results.size() == 0)
                begin
                    report_mismatch($sformatf("result with nothing pending: value %0d status %0d",
                                              out_value, status));
                end
                else
                begin
                    exp_r = pending_results.pop_front();
                    if (out_value !== exp_r.value)
                    begin
                        report_mismatch($sformatf("out_value %0d, expected %0d",
                                                  out_value, exp_r.value));
                    end
                    if (status !== exp_r.stat)
                    begin
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  status, exp_r.stat));
                    end
                    if (is_last !== exp_r.last)
                    begin
                        report_mismatch($sformatf("is_last %0b, expected %0b",
                                                  is_last, exp_r.last));
                    end
                end
            end
            if ((start && !busy) || done)
            begin
                stall_cycles = 0;
            end
            else
            begin
                stall_cycles++;
            end
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin
        error_count  = 0;
        stall_cycles = 0;
        mirror_front = 0;
        mirror_count = 0;
        start        = 1'b0;
        req_type     = deq_pkg::REQ_PUSH_FRONT;
        push_value   = VAL_ZERO;
        rst_n        = 1'b0;
        repeat (3)
        begin
            @(negedge clk);
        end
        rst_n <= 1'b1;

        test_empty_queue();
        test_value_extremes();
        test_full_queue();
        test_random_traffic();
        test_back_to_back();

        wait_for_drain();
        repeat (TAIL_CYCLES)
        begin
            @(posedge clk);
        end
        if (error_count == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/deq_pkg.sv
hw/rtl/deq_ram.sv
hw/rtl/double_ended_queue.sv
tb/sv/double_ended_queue_tb.sv
